// ===== src/npal_pkg.sv =====
`timescale 1ns / 1ps
// npal_pkg: shared codes and bus widths for the nine-patch axis layout block
// no dependencies; imported by npal_cfg and nine_patch_axis_layout

package npal_pkg;

    // configuration bus geometry
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    // register map, one 32-bit word per register
    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMAGE_SIZE    = 3'd0,
        REG_STRETCH_START = 3'd1,
        REG_STRETCH_END   = 3'd2,
        REG_PAD_START     = 3'd3,
        REG_PAD_END       = 3'd4
    } t_reg_idx;

    // content alignment codes
    typedef enum logic [1:0] {
        ALIGN_START  = 2'd0,
        ALIGN_END    = 2'd1,
        ALIGN_CENTER = 2'd2
    } t_align;

endpackage

// ===== src/npal_cfg.sv =====
`timescale 1ns / 1ps
// npal_cfg: APB-style register file holding the axis geometry
// depends on npal_pkg for the register map and bus widths

module npal_cfg
    import npal_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [COORD_BITS-1:0] o_image_size,
    output logic [COORD_BITS-1:0] o_stretch_start,
    output logic [COORD_BITS-1:0] o_stretch_end,
    output logic [COORD_BITS-1:0] o_pad_start,
    output logic [COORD_BITS-1:0] o_pad_end
);

    logic [REG_IDX_W-1:0]  w_idx;
    logic                  w_wr;
    logic [COORD_BITS-1:0] r_image_size, n_image_size;
    logic [COORD_BITS-1:0] r_stretch_start, n_stretch_start;
    logic [COORD_BITS-1:0] r_stretch_end, n_stretch_end;
    logic [COORD_BITS-1:0] r_pad_start, n_pad_start;
    logic [COORD_BITS-1:0] r_pad_end, n_pad_end;

    // word index and write strobe of the access phase
    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    // register write decode
    always_comb begin
        n_image_size    = r_image_size;
        n_stretch_start = r_stretch_start;
        n_stretch_end   = r_stretch_end;
        n_pad_start     = r_pad_start;
        n_pad_end       = r_pad_end;
        if (w_wr) begin
            unique case (t_reg_idx'(w_idx))
                REG_IMAGE_SIZE:    n_image_size    = pwdata[COORD_BITS-1:0];
                REG_STRETCH_START: n_stretch_start = pwdata[COORD_BITS-1:0];
                REG_STRETCH_END:   n_stretch_end   = pwdata[COORD_BITS-1:0];
                REG_PAD_START:     n_pad_start     = pwdata[COORD_BITS-1:0];
                REG_PAD_END:       n_pad_end       = pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size    <= '0;
            r_stretch_start <= '0;
            r_stretch_end   <= '0;
            r_pad_start     <= '0;
            r_pad_end       <= '0;
        end else begin
            r_image_size    <= n_image_size;
            r_stretch_start <= n_stretch_start;
            r_stretch_end   <= n_stretch_end;
            r_pad_start     <= n_pad_start;
            r_pad_end       <= n_pad_end;
        end
    end

    // read mux
    always_comb begin
        unique case (t_reg_idx'(w_idx))
            REG_IMAGE_SIZE:    prdata = APB_DATA_W'(r_image_size);
            REG_STRETCH_START: prdata = APB_DATA_W'(r_stretch_start);
            REG_STRETCH_END:   prdata = APB_DATA_W'(r_stretch_end);
            REG_PAD_START:     prdata = APB_DATA_W'(r_pad_start);
            REG_PAD_END:       prdata = APB_DATA_W'(r_pad_end);
            default:           prdata = '0;
        endcase
    end

    assign o_image_size    = r_image_size;
    assign o_stretch_start = r_stretch_start;
    assign o_stretch_end   = r_stretch_end;
    assign o_pad_start     = r_pad_start;
    assign o_pad_end       = r_pad_end;

endmodule

// ===== src/npal_div_cell.sv =====
`timescale 1ns / 1ps
// npal_div_cell: one restoring-division step for two lanes sharing a divisor
// no package dependencies; chained COORD_BITS times in nine_patch_axis_layout

module npal_div_cell #(
    parameter int COORD_BITS = 12,
    parameter int SIDE_W     = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [COORD_BITS:0]     i_div,
    input  logic [2*COORD_BITS:0]   i_acc_a,
    input  logic [2*COORD_BITS:0]   i_acc_b,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [COORD_BITS:0]     o_div,
    output logic [2*COORD_BITS:0]   o_acc_a,
    output logic [2*COORD_BITS:0]   o_acc_b,
    output logic [SIDE_W-1:0]       o_side
);

    localparam int ACC_W = 2 * COORD_BITS + 1;

    logic                  r_valid;
    logic [COORD_BITS:0]   r_div;
    logic [ACC_W-1:0]      r_acc_a, n_acc_a;
    logic [ACC_W-1:0]      r_acc_b, n_acc_b;
    logic [SIDE_W-1:0]     r_side;
    logic                  w_load;

    // shift the partial remainder left one bit, subtract the divisor if it fits,
    // and shift the quotient bit into the low end
    function automatic logic [ACC_W-1:0] div_step(
        input logic [ACC_W-1:0]    acc,
        input logic [COORD_BITS:0] div
    );
        logic [ACC_W:0]        sh;
        logic [COORD_BITS+1:0] hi;
        logic [COORD_BITS+1:0] d_ext;
        logic [ACC_W-1:0]      res;
        sh    = {acc, 1'b0};
        hi    = sh[ACC_W:COORD_BITS];
        d_ext = {1'b0, div};
        res   = {hi[COORD_BITS:0], sh[COORD_BITS-1:0]};
        if (hi >= d_ext) begin
            hi  = hi - d_ext;
            res = {hi[COORD_BITS:0], sh[COORD_BITS-1:1], 1'b1};
        end
        return res;
    endfunction

    // stage handshake: hold while the neighbor stalls
    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    assign n_acc_a = div_step(i_acc_a, i_div);
    assign n_acc_b = div_step(i_acc_b, i_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_div   <= i_div;
            r_acc_a <= n_acc_a;
            r_acc_b <= n_acc_b;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_acc_a = r_acc_a;
    assign o_acc_b = r_acc_b;
    assign o_side  = r_side;

    // partial remainders always stay below the divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_div != '0) |->
            (r_acc_a[ACC_W-1:COORD_BITS] < r_div) && (r_acc_b[ACC_W-1:COORD_BITS] < r_div))
        else $error("division cell remainder not below divisor");

    // a stalled cell keeps its transaction intact
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=>
            r_valid && $stable(r_acc_a) && $stable(r_acc_b) && $stable(r_div))
        else $error("division cell lost state while stalled");

endmodule

// ===== src/nine_patch_axis_layout.sv =====
`timescale 1ns / 1ps
// nine_patch_axis_layout: one-axis nine-patch layout, fully pipelined
// path: input register, stages 2 and 3, the division cells, then stages F1, F2, F3
// throughput: one transaction per cycle unless stalled; the rounded pad scaling
//   runs through a row of COORD_BITS division stages, one quotient bit per cell
// reset: synchronous, clears all stage valid bits and the geometry registers to zero
// depends on npal_pkg, npal_cfg, npal_div_cell

module nine_patch_axis_layout
    import npal_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [COORD_BITS-1:0]        i_draw_size,
    input  logic [1:0]                   i_align,
    input  logic [COORD_BITS-1:0]        i_content_size,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS+1:0] o_position,
    output logic [COORD_BITS:0]          o_scaled_pad_start,
    output logic [COORD_BITS:0]          o_scaled_pad_end,
    output logic [COORD_BITS:0]          o_pad_size,
    output logic [COORD_BITS-1:0]        o_stretch_size
);

    localparam int ACC_W  = 2 * COORD_BITS + 1;
    localparam int EDGE_W = COORD_BITS + 1;
    localparam int POS_W  = COORD_BITS + 2;
    localparam int SIDE_W = 2 + COORD_BITS + 2 * EDGE_W + 2 + COORD_BITS;

    // geometry registers
    logic [COORD_BITS-1:0] w_image_size, w_stretch_start, w_stretch_end;
    logic [COORD_BITS-1:0] w_pad_start, w_pad_end;

    npal_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_image_size    (w_image_size),
        .o_stretch_start (w_stretch_start),
        .o_stretch_end   (w_stretch_end),
        .o_pad_start     (w_pad_start),
        .o_pad_end       (w_pad_end)
    );

    // static quantities derived from the geometry
    logic [COORD_BITS-1:0] w_swa;
    logic [COORD_BITS-1:0] w_tail;
    logic [COORD_BITS:0]   w_lim;

    assign w_swa  = (w_stretch_end > w_stretch_start) ? (w_stretch_end - w_stretch_start) : '0;
    assign w_tail = (w_image_size > w_stretch_end) ? (w_image_size - w_stretch_end) : '0;
    assign w_lim  = {1'b0, w_stretch_start} + {1'b0, w_tail};

    // stage 1: input register
    logic                  r_s1_valid, w_s1_ready;
    logic [COORD_BITS-1:0] r_s1_draw, r_s1_content;
    logic [1:0]            r_s1_align;
    logic                  w_s2_ready;

    assign w_s1_ready = !r_s1_valid || w_s2_ready;
    assign o_ready    = w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_s1_ready) begin
            r_s1_draw    <= i_draw_size;
            r_s1_align   <= i_align;
            r_s1_content <= i_content_size;
        end
    end

    // stage 2: stretch size at the drawn size
    logic                  r_s2_valid, r_s2_natural, n_s2_natural;
    logic [COORD_BITS-1:0] r_s2_swb, n_s2_swb;
    logic [COORD_BITS-1:0] r_s2_content;
    logic [1:0]            r_s2_align;
    logic [COORD_BITS-1:0] w_diff;
    logic                  w_s3_ready;

    // only used when the draw size exceeds the limit, so the low bits suffice
    assign n_s2_natural = (r_s1_draw == '0) || (r_s1_draw == w_image_size);
    assign w_diff       = r_s1_draw - w_lim[COORD_BITS-1:0];
    assign n_s2_swb     = n_s2_natural ? w_swa :
                          (({1'b0, r_s1_draw} > w_lim) ? w_diff : '0);
    assign w_s2_ready   = !r_s2_valid || w_s3_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_s2_ready) begin
            r_s2_natural <= n_s2_natural;
            r_s2_swb     <= n_s2_swb;
            r_s2_align   <= r_s1_align;
            r_s2_content <= r_s1_content;
        end
    end

    // stage 3: classify pad edges, form the rounded-division numerators
    logic [COORD_BITS-1:0]   w_pad [2];
    logic [1:0]              w_below, w_inside;
    logic [COORD_BITS-1:0]   w_x [2];
    logic [2*COORD_BITS-1:0] w_prod [2];
    logic [EDGE_W-1:0]       w_above [2];
    logic [ACC_W-1:0]        n_s3_acc [2];
    logic [EDGE_W-1:0]       n_s3_base [2];

    assign w_pad[0] = w_pad_start;
    assign w_pad[1] = w_pad_end;

    for (genvar L = 0; L < 2; L++) begin : g_edge
        assign w_below[L]   = r_s2_natural || (w_pad[L] <= w_stretch_start);
        assign w_inside[L]  = !w_below[L] && (w_pad[L] < w_stretch_end);
        assign w_x[L]       = w_pad[L] - w_stretch_start;
        assign w_prod[L]    = (2*COORD_BITS)'(r_s2_swb) * (2*COORD_BITS)'(w_x[L]);
        assign n_s3_acc[L]  = w_inside[L] ? ({w_prod[L], 1'b0} + ACC_W'(w_swa)) : '0;
        assign w_above[L]   = EDGE_W'(w_stretch_start) + EDGE_W'(r_s2_swb)
                            + EDGE_W'(w_pad[L]) - EDGE_W'(w_stretch_end);
        assign n_s3_base[L] = w_below[L] ? EDGE_W'(w_pad[L]) :
                              (w_inside[L] ? EDGE_W'(w_stretch_start) : w_above[L]);
    end

    logic                r_s3_valid;
    logic [ACC_W-1:0]    r_s3_acc [2];
    logic [COORD_BITS:0] r_s3_div;
    logic [SIDE_W-1:0]   r_s3_side;
    logic                w_row_ready;

    assign w_s3_ready = !r_s3_valid || w_row_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_s3_ready) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && w_s3_ready) begin
            r_s3_acc  <= n_s3_acc;
            r_s3_div  <= {w_swa, 1'b0};
            r_s3_side <= {r_s2_align, r_s2_content, n_s3_base[0], n_s3_base[1],
                          w_inside[0], w_inside[1], r_s2_swb};
        end
    end

    // division row: one quotient bit per cell
    logic                w_cv [COORD_BITS+1];
    logic                w_cr [COORD_BITS+1];
    logic [COORD_BITS:0] w_div [COORD_BITS+1];
    logic [ACC_W-1:0]    w_acc_a [COORD_BITS+1];
    logic [ACC_W-1:0]    w_acc_b [COORD_BITS+1];
    logic [SIDE_W-1:0]   w_side [COORD_BITS+1];
    logic                w_f1_ready;

    assign w_cv[0]    = r_s3_valid;
    assign w_div[0]   = r_s3_div;
    assign w_acc_a[0] = r_s3_acc[0];
    assign w_acc_b[0] = r_s3_acc[1];
    assign w_side[0]  = r_s3_side;
    assign w_row_ready = w_cr[0];
    assign w_cr[COORD_BITS] = w_f1_ready;

    for (genvar k = 0; k < COORD_BITS; k++) begin : g_cell
        npal_div_cell #(
            .COORD_BITS (COORD_BITS),
            .SIDE_W     (SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[k]),
            .o_ready (w_cr[k]),
            .i_div   (w_div[k]),
            .i_acc_a (w_acc_a[k]),
            .i_acc_b (w_acc_b[k]),
            .i_side  (w_side[k]),
            .o_valid (w_cv[k+1]),
            .i_ready (w_cr[k+1]),
            .o_div   (w_div[k+1]),
            .o_acc_a (w_acc_a[k+1]),
            .o_acc_b (w_acc_b[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    // stage F1: scaled pad edges
    logic [1:0]            w_row_align;
    logic [COORD_BITS-1:0] w_row_content, w_row_swb;
    logic [EDGE_W-1:0]     w_row_base_s, w_row_base_e;
    logic                  w_row_ins_s, w_row_ins_e;
    logic [EDGE_W-1:0]     n_f1_ps, n_f1_pe;

    assign {w_row_align, w_row_content, w_row_base_s, w_row_base_e,
            w_row_ins_s, w_row_ins_e, w_row_swb} = w_side[COORD_BITS];

    assign n_f1_ps = w_row_base_s +
                     (w_row_ins_s ? {1'b0, w_acc_a[COORD_BITS][COORD_BITS-1:0]} : '0);
    assign n_f1_pe = w_row_base_e +
                     (w_row_ins_e ? {1'b0, w_acc_b[COORD_BITS][COORD_BITS-1:0]} : '0);

    logic                  r_f1_valid;
    logic [EDGE_W-1:0]     r_f1_ps, r_f1_pe;
    logic [1:0]            r_f1_align;
    logic [COORD_BITS-1:0] r_f1_content, r_f1_swb;
    logic                  w_f2_ready;

    assign w_f1_ready = !r_f1_valid || w_f2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (w_f1_ready) begin
            r_f1_valid <= w_cv[COORD_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cv[COORD_BITS] && w_f1_ready) begin
            r_f1_ps      <= n_f1_ps;
            r_f1_pe      <= n_f1_pe;
            r_f1_align   <= w_row_align;
            r_f1_content <= w_row_content;
            r_f1_swb     <= w_row_swb;
        end
    end

    // stage F2: pad size, clamped at zero
    logic                  r_f2_valid;
    logic [EDGE_W-1:0]     r_f2_ps, r_f2_pe, r_f2_psize, n_f2_psize;
    logic [1:0]            r_f2_align;
    logic [COORD_BITS-1:0] r_f2_content, r_f2_swb;
    logic                  w_f3_ready;

    assign n_f2_psize = (r_f1_pe > r_f1_ps) ? (r_f1_pe - r_f1_ps) : '0;
    assign w_f2_ready = !r_f2_valid || w_f3_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_valid <= 1'b0;
        end else if (w_f2_ready) begin
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f1_valid && w_f2_ready) begin
            r_f2_ps      <= r_f1_ps;
            r_f2_pe      <= r_f1_pe;
            r_f2_psize   <= n_f2_psize;
            r_f2_align   <= r_f1_align;
            r_f2_content <= r_f1_content;
            r_f2_swb     <= r_f1_swb;
        end
    end

    // stage F3: aligned position, output register
    logic [POS_W-1:0] n_f3_pos;

    always_comb begin
        unique case (t_align'(r_f2_align))
            ALIGN_START:  n_f3_pos = POS_W'(r_f2_ps);
            ALIGN_END:    n_f3_pos = POS_W'(r_f2_pe) - POS_W'(r_f2_content);
            ALIGN_CENTER: n_f3_pos = POS_W'(r_f2_ps) + POS_W'(r_f2_psize >> 1)
                                   - POS_W'(r_f2_content >> 1);
            default:      n_f3_pos = '0;
        endcase
    end

    logic                  r_f3_valid;
    logic [POS_W-1:0]      r_f3_pos;
    logic [EDGE_W-1:0]     r_f3_ps, r_f3_pe, r_f3_psize;
    logic [COORD_BITS-1:0] r_f3_swb;

    assign w_f3_ready = !r_f3_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_valid <= 1'b0;
        end else if (w_f3_ready) begin
            r_f3_valid <= r_f2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f2_valid && w_f3_ready) begin
            r_f3_pos   <= n_f3_pos;
            r_f3_ps    <= r_f2_ps;
            r_f3_pe    <= r_f2_pe;
            r_f3_psize <= r_f2_psize;
            r_f3_swb   <= r_f2_swb;
        end
    end

    assign o_valid            = r_f3_valid;
    assign o_position         = r_f3_pos;
    assign o_scaled_pad_start = r_f3_ps;
    assign o_scaled_pad_end   = r_f3_pe;
    assign o_pad_size         = r_f3_psize;
    assign o_stretch_size     = r_f3_swb;

    // an accepted transaction always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_s1_valid)
        else $error("accepted transaction missing from input stage");

    // a nonzero pad size implies ordered scaled edges
    a_pad_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_pad_size != '0) |-> (o_scaled_pad_end > o_scaled_pad_start))
        else $error("pad size inconsistent with scaled edges");

    // an empty output register always takes the transaction behind it
    a_tail_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f2_valid && !r_f3_valid |=> r_f3_valid)
        else $error("output register failed to take a waiting transaction");

endmodule
